/* rtl/core/ssp_pkg.sv */
// Shared types and constants for the servo shutter positioner.
package ssp_pkg;

  localparam logic [1:0] KindTick  = 2'd0;
  localparam logic [1:0] KindOpen  = 2'd1;
  localparam logic [1:0] KindClose = 2'd2;

  localparam logic [7:0] RegStep   = 8'd0;
  localparam logic [7:0] RegSettle = 8'd1;
  localparam logic [7:0] RegRetry  = 8'd2;
  localparam logic [7:0] RegPeriod = 8'd3;

  localparam logic [7:0]  StepReset    = 8'd1;
  localparam logic [15:0] SettleReset  = 16'd1000;
  localparam logic [15:0] RetryReset   = 16'd100;
  localparam logic [15:0] PeriodReset  = 16'd20310;
  localparam logic [7:0]  OpenReset    = 8'd205;
  localparam logic [7:0]  CloseReset   = 8'd105;
  localparam logic [15:0] CompareReset = 16'd558;

  localparam logic [7:0] AngleLimit  = 8'd170;
  localparam logic [7:0] CloseOffset = 8'd50;

  // x / 2000 = (x >> 4) / 125; 125 done as multiply by ceil(2^27/125), exact below 2^20
  localparam int unsigned DivShift = 27;
  localparam logic [20:0] DivRecip = 21'd1073742;

  typedef struct packed {
    logic        upd;
    logic [7:0]  base;
    logic [15:0] period;
    logic        busy;
    logic        done;
    logic        closing;
  } item_t;

endpackage

/* rtl/core/servo_shutter_positioner.sv */
// Servo shutter positioner top level: config registers, sequencer and compare scaling.
//
// Input stream: s_axis_tuser carries the item kind (tick, open, close), s_axis_tdata
// the two active-low sensor levels. Every accepted transaction gives exactly one
// result transaction on m_axis: compare value, busy, done and closing flags.
// An item passes the input register, the sequencing stage, the period*base multiply
// stage and the reciprocal divide stage feeding the result register; one item per cycle
// is sustained while the receiver keeps m_axis_tready high.
// Each stage loads when it is empty or the next one loads, so input keeps being
// accepted while a result waits until all stages are full; with the receiver
// stalled, s_axis_tready drops after four items are held.
// Config writes (cfg_valid_i/cfg_ready_o) are taken every cycle; indexes 0..3 select
// correction step, settle ticks, retry ticks and PWM period, others are ignored.
// Reset clears all stages, loads the default registers, open angle 205, close
// angle 105, idle phase and a compare value of 558.
module servo_shutter_positioner import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [0] sensor_one_level, [1] sensor_two_level
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] compare_value, [16] busy_res,
                                     // [17] done_res, [18] closing
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [7:0]  step_q;
  logic [15:0] settle_q, retry_q, period_q;
  logic        mid_valid, mid_ready, busy, done, closing;
  item_t       mid_item;
  logic [15:0] compare;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= StepReset;
      settle_q <= SettleReset;
      retry_q  <= RetryReset;
      period_q <= PeriodReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegStep:   step_q   <= cfg_data_i[7:0];
        RegSettle: settle_q <= cfg_data_i;
        RegRetry:  retry_q  <= cfg_data_i;
        RegPeriod: period_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  ssp_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .sens1_i     (s_axis_tdata[0]),
    .sens2_i     (s_axis_tdata[1]),
    .step_i      (step_q),
    .settle_i    (settle_q),
    .retry_i     (retry_q),
    .period_i    (period_q),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_item_o  (mid_item)
  );

  ssp_scale u_scale (
    .clk_i,
    .rst_ni,
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .item_i      (mid_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .compare_o   (compare),
    .busy_o      (busy),
    .done_o      (done),
    .closing_o   (closing)
  );

  assign m_axis_tdata = {5'b00000, closing, done, busy, compare};

endmodule

/* rtl/core/ssp_ctrl.sv */
// Input register and shutter sequencing state update.
module ssp_ctrl import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic        sens1_i,
  input  logic        sens2_i,
  input  logic [7:0]  step_i,
  input  logic [15:0] settle_i,
  input  logic [15:0] retry_i,
  input  logic [15:0] period_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output item_t       out_item_o
);

  typedef enum logic [1:0] {PhIdle, PhSettle, PhRetry} phase_e;

  logic        v1_q, v2_q;
  logic [1:0]  kind1_q;
  logic        sens1_q, sens2_q;
  item_t       item2_q, item_d;

  logic [7:0]  open_q, open_d, close_q, close_d;
  logic [15:0] wait_q, wait_d;
  phase_e      phase_q, phase_d;
  logic        dir_q, dir_d;

  logic        ld2, is_cmd, is_tick, active, check, down, up, ok, apply, done;
  logic [7:0]  cur, clamped;
  logic signed [9:0] adj, sum;

  assign ld2        = v1_q && (!v2_q || out_ready_i);
  assign in_ready_o = !v1_q || ld2;

  assign is_cmd  = (kind1_q == KindOpen) || (kind1_q == KindClose);
  assign is_tick = (kind1_q == KindTick);
  assign active  = (phase_q == PhSettle) || (phase_q == PhRetry);
  assign check   = is_tick && active && (wait_q <= 16'd1);

  always_comb begin
    dir_d = is_cmd ? (kind1_q == KindClose) : dir_q;
    cur   = dir_d ? close_q : open_q;
    if (dir_q) begin
      down = sens2_q;
      up   = !sens2_q && sens1_q;
    end else begin
      down = !sens1_q;
      up   = 1'b0;
    end
    ok = !down && !up;
    if (is_cmd) adj = 10'sd0;
    else if (down) adj = -$signed({2'b00, step_i});
    else if (up) adj = $signed({2'b00, step_i});
    else adj = 10'sd0;
    sum = $signed({2'b00, cur}) + adj;
    if (sum < 10'sd0) clamped = 8'd0;
    else if (sum > $signed({2'b00, AngleLimit})) clamped = AngleLimit;
    else clamped = sum[7:0];

    open_d  = open_q;
    close_d = close_q;
    wait_d  = wait_q;
    phase_d = phase_q;
    apply   = 1'b0;
    done    = 1'b0;
    if (is_cmd) begin
      apply   = 1'b1;
      wait_d  = settle_i;
      phase_d = PhSettle;
    end else if (is_tick && active) begin
      if (!check) begin
        wait_d = wait_q - 16'd1;
      end else if (ok) begin
        wait_d  = 16'd0;
        done    = 1'b1;
        phase_d = PhIdle;
      end else begin
        apply   = 1'b1;
        wait_d  = retry_i;
        phase_d = PhRetry;
      end
    end
    if (apply) begin
      if (dir_d) close_d = clamped;
      else open_d = clamped;
    end

    item_d.upd     = apply;
    item_d.base    = dir_d ? clamped + CloseOffset : clamped;
    item_d.period  = period_i;
    item_d.busy    = (phase_d == PhSettle) || (phase_d == PhRetry);
    item_d.done    = done;
    item_d.closing = dir_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      open_q  <= OpenReset;
      close_q <= CloseReset;
      wait_q  <= 16'd0;
      phase_q <= PhIdle;
      dir_q   <= 1'b0;
      item2_q <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        v1_q <= 1'b1;
      end else if (ld2) begin
        v1_q <= 1'b0;
      end
      if (ld2) begin
        v2_q    <= 1'b1;
        open_q  <= open_d;
        close_q <= close_d;
        wait_q  <= wait_d;
        phase_q <= phase_d;
        dir_q   <= dir_d;
        item2_q <= item_d;
      end else if (out_ready_i) begin
        v2_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind1_q <= kind_i;
      sens1_q <= sens1_i;
      sens2_q <= sens2_i;
    end
  end

  assign out_valid_o = v2_q;
  assign out_item_o  = item2_q;

`ifndef SYNTHESIS
  a_tick_keeps_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld2 && is_tick) |=> $stable(dir_q)) else $error("tick changed direction");
  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld2 && item_d.done) |=> (phase_q == PhIdle)) else $error("done without idle");
  a_angles_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld2 && !item_d.upd) |=> ($stable(open_q) && $stable(close_q)))
    else $error("angle moved without apply");
`endif

endmodule

/* rtl/core/ssp_scale.sv */
// Compare value scaling: period * base / 2000, and the output register.
module ssp_scale import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  item_t       item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] compare_o,
  output logic        busy_o,
  output logic        done_o,
  output logic        closing_o
);

  logic        v3_q, v4_q, ld3, ld4;
  logic        upd3_q, busy3_q, done3_q, close3_q;
  logic        busy4_q, done4_q, close4_q;
  logic [23:0] prod3_q;
  logic [19:0] div_in;
  logic [40:0] recip_prod;
  logic [15:0] quot, cmp_q;

  assign ld4        = v3_q && (!v4_q || out_ready_i);
  assign in_ready_o = !v3_q || ld4;
  assign ld3        = in_valid_i && in_ready_o;

  assign div_in     = prod3_q[23:4];
  assign recip_prod = 41'(div_in) * 41'(DivRecip);
  assign quot       = 16'(recip_prod[40:DivShift]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      cmp_q <= CompareReset;
    end else begin
      if (ld3) begin
        v3_q <= 1'b1;
      end else if (ld4) begin
        v3_q <= 1'b0;
      end
      if (ld4) begin
        v4_q <= 1'b1;
        if (upd3_q) cmp_q <= quot;
      end else if (out_ready_i) begin
        v4_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      prod3_q  <= 24'(item_i.period) * 24'(item_i.base);
      upd3_q   <= item_i.upd;
      busy3_q  <= item_i.busy;
      done3_q  <= item_i.done;
      close3_q <= item_i.closing;
    end
    if (ld4) begin
      busy4_q  <= busy3_q;
      done4_q  <= done3_q;
      close4_q <= close3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign compare_o   = cmp_q;
  assign busy_o      = busy4_q;
  assign done_o      = done4_q;
  assign closing_o   = close4_q;

`ifndef SYNTHESIS
  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !out_ready_i) |=> (v4_q && $stable(cmp_q))) else $error("held result changed");
  a_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld4 && !upd3_q) |=> $stable(cmp_q)) else $error("compare changed without apply");
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !ld4) |=> (v3_q && $stable(prod3_q))) else $error("product stage lost");
`endif

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the servo shutter positioner stream block.
module tb_top import ssp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KindSpare = 2'd3;
  localparam int ScaleDiv = 2000;
  localparam int NumPhases = 10;
  localparam int PhaseItems = 195;
  localparam int HoldCycles = 60;
  localparam int DrainCycles = 8;
  localparam int WatchdogLimit = 1000;
  localparam int MaxPrinted = 50;

  typedef enum logic [1:0] {SeqIdle, SeqSettle, SeqRetry} seq_phase_e;
  typedef enum int {RxFree, RxRandom, RxPattern} rx_style_e;

  typedef struct packed {
    logic [15:0] cmp;
    logic        busy;
    logic        done;
    logic        closing;
  } position_t;

  typedef struct packed {
    logic        is_write;
    logic [7:0]  reg_idx;
    logic [15:0] reg_val;
    logic [1:0]  kind;
    logic        s1;
    logic        s2;
    logic        typed;
    position_t   want;
  } stim_row_t;

  localparam stim_row_t DirectedRows [24] = '{
    '{1'b0, 8'd0, 16'd0, KindTick, 1'b1, 1'b1, 1'b1, '{16'd558, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, KindSpare, 1'b0, 1'b0, 1'b1, '{16'd558, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, KindOpen, 1'b1, 1'b1, 1'b1, '{16'd1726, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, KindClose, 1'b1, 1'b1, 1'b1, '{16'd1574, 1'b1, 1'b0, 1'b1}},
    '{1'b0, 8'd0, 16'd0, KindTick, 1'b0, 1'b0, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b1, RegSettle, 16'd0, KindTick, 1'b1, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b1, RegRetry, 16'd0, KindTick, 1'b1, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b1, RegStep, 16'hFF00, KindTick, 1'b1, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, KindOpen, 1'b0, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, KindTick, 1'b0, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, KindTick, 1'b1, 1'b0, 1'b1, '{16'd1726, 1'b0, 1'b1, 1'b0}},
    '{1'b1, RegStep, 16'h00AA, KindTick, 1'b1, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b1, RegPeriod, 16'hFFFF, KindTick, 1'b1, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, KindClose, 1'b1, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, KindTick, 1'b1, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, KindTick, 1'b1, 1'b0, 1'b1, '{16'd7208, 1'b1, 1'b0, 1'b1}},
    '{1'b0, 8'd0, 16'd0, KindTick, 1'b0, 1'b0, 1'b1, '{16'd7208, 1'b0, 1'b1, 1'b1}},
    '{1'b0, 8'd0, 16'd0, KindTick, 1'b0, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b1, RegPeriod, 16'd0, KindTick, 1'b1, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b1, 8'hFF, 16'hFFFF, KindTick, 1'b1, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b1, RegStep, 16'h00FF, KindTick, 1'b1, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, KindOpen, 1'b0, 1'b1, 1'b1, '{16'd0, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, KindTick, 1'b0, 1'b0, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, KindTick, 1'b0, 1'b1, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // shutter model state and its copy of the registers
  logic [7:0]  step_r;
  logic [15:0] settle_r;
  logic [15:0] retry_r;
  logic [15:0] period_r;
  logic [7:0]  open_deg;
  logic [7:0]  close_deg;
  logic [15:0] wait_left;
  seq_phase_e  seq;
  logic        dir_close;
  logic [15:0] compare_q;

  position_t   pending_positions[$];
  position_t   got_pos;
  position_t   want_pos;

  int          mismatch_count;
  int          items_sent;
  int          results_seen;
  int          commands_sent;
  int          confirms_seen;
  int          writes_done;
  int          long_holds;
  int          burst_left;
  int          rx_tick;
  int          quiet_cycles;
  bit          tx_gappy;
  bit          hold_request;
  rx_style_e   rx_style;

  servo_shutter_positioner i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what, input int unsigned got, input int unsigned want);
    if (mismatch_count < MaxPrinted) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic void swing_to(input int delta);
    int target;
    int base;
    target = (dir_close ? int'(close_deg) : int'(open_deg)) + delta;
    if (target > int'(AngleLimit)) target = int'(AngleLimit);
    if (target < 0) target = 0;
    if (dir_close) begin
      close_deg = 8'(target);
      base = target + int'(CloseOffset);
    end else begin
      open_deg = 8'(target);
      base = target;
    end
    compare_q = 16'((int'(period_r) * base) / ScaleDiv);
  endfunction

  function automatic position_t advance_shutter(input logic [1:0] kind, input logic s1,
                                                input logic s2);
    position_t res;
    int delta;
    bit ok;
    res = '0;
    delta = 0;
    ok = 1'b0;
    if (kind == KindOpen || kind == KindClose) begin
      dir_close = (kind == KindClose);
      swing_to(0);
      wait_left = settle_r;
      seq = SeqSettle;
    end else if (kind == KindTick && seq != SeqIdle) begin
      if (wait_left > 16'd1) begin
        wait_left = wait_left - 16'd1;
      end else begin
        wait_left = '0;
        if (dir_close) begin
          if (s2) delta = -int'(step_r);
          else if (s1) delta = int'(step_r);
          else ok = 1'b1;
        end else begin
          if (!s1) delta = -int'(step_r);
          else ok = 1'b1;
        end
        if (ok) begin
          res.done = 1'b1;
          seq = SeqIdle;
        end else begin
          swing_to(delta);
          wait_left = retry_r;
          seq = SeqRetry;
        end
      end
    end
    res.cmp = compare_q;
    res.busy = (seq != SeqIdle);
    res.closing = dir_close;
    return res;
  endfunction

  // Keeps valid high across back-to-back transactions; lowers it only for a real gap.
  task automatic offer_item(input logic [1:0] kind, input logic s1, input logic s2);
    int gap;
    if (tx_gappy && burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, s2, s1};
    s_axis_tuser <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    items_sent++;
    if (kind == KindOpen || kind == KindClose) commands_sent++;
  endtask

  task automatic await_drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_positions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegStep:   step_r = val[7:0];
      RegSettle: settle_r = val;
      RegRetry:  retry_r = val;
      RegPeriod: period_r = val;
      default: ;
    endcase
    writes_done++;
    @(posedge clk_i);
  endtask

  // receiver: own stall pattern, plus one long hold-off on request
  initial begin
    rx_tick = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        long_holds++;
      end else begin
        case (rx_style)
          RxFree:   m_axis_tready <= 1'b1;
          RxRandom: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default:  m_axis_tready <= ((rx_tick % 7) < 4);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      got_pos = '{m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tdata[17], m_axis_tdata[18]};
      results_seen++;
      if (pending_positions.size() == 0) begin
        flag_mismatch("result with nothing pending", got_pos.cmp, 0);
      end else begin
        want_pos = pending_positions.pop_front();
        if (want_pos.done) confirms_seen++;
        if (got_pos.cmp !== want_pos.cmp)
          flag_mismatch("compare_value", got_pos.cmp, want_pos.cmp);
        if (got_pos.busy !== want_pos.busy)
          flag_mismatch("busy_res", got_pos.busy, want_pos.busy);
        if (got_pos.done !== want_pos.done)
          flag_mismatch("done_res", got_pos.done, want_pos.done);
        if (got_pos.closing !== want_pos.closing)
          flag_mismatch("closing", got_pos.closing, want_pos.closing);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
    $display("Verification failed");
    $finish;
  end

  initial begin
    position_t   predicted;
    logic [7:0]  step_v;
    logic [15:0] settle_v;
    logic [15:0] retry_v;
    logic [15:0] period_v;
    logic [1:0]  kind_v;
    int          pick;

    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    mismatch_count = 0;
    items_sent = 0;
    results_seen = 0;
    commands_sent = 0;
    confirms_seen = 0;
    writes_done = 0;
    long_holds = 0;
    burst_left = 0;
    tx_gappy = 1'b0;
    hold_request = 1'b0;
    rx_style = RxRandom;

    step_r = StepReset;
    settle_r = SettleReset;
    retry_r = RetryReset;
    period_r = PeriodReset;
    open_deg = OpenReset;
    close_deg = CloseReset;
    wait_left = '0;
    seq = SeqIdle;
    dir_close = 1'b0;
    compare_q = CompareReset;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[r]) begin
      if (DirectedRows[r].is_write) begin
        await_drain();
        write_reg(DirectedRows[r].reg_idx, DirectedRows[r].reg_val);
      end else begin
        offer_item(DirectedRows[r].kind, DirectedRows[r].s1, DirectedRows[r].s2);
        predicted = advance_shutter(DirectedRows[r].kind, DirectedRows[r].s1,
                                    DirectedRows[r].s2);
        pending_positions.push_back(DirectedRows[r].typed ? DirectedRows[r].want : predicted);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      await_drain();
      step_v = 8'($urandom_range(1, 170));
      settle_v = 16'($urandom_range(1, 4));
      retry_v = 16'($urandom_range(1, 4));
      period_v = 16'($urandom_range(1, 65535));
      case (p)
        1: begin
          settle_v = '0;
          retry_v = '0;
        end
        2: step_v = '0;
        3: begin
          step_v = 8'd170;
          period_v = 16'hFFFF;
        end
        4: period_v = '0;
        5: begin
          settle_v = 16'hFFFF;
          retry_v = 16'hFFFF;
        end
        6: begin
          step_v = 8'hFF;
          period_v = 16'd1;
          settle_v = 16'd1;
          retry_v = 16'd1;
        end
        9: begin
          settle_v = 16'($urandom_range(2, 30));
          retry_v = 16'($urandom_range(2, 30));
        end
        default: ;
      endcase
      write_reg(RegStep, {8'($urandom_range(0, 255)), step_v});
      write_reg(RegSettle, settle_v);
      write_reg(RegRetry, retry_v);
      write_reg(RegPeriod, period_v);
      write_reg(8'($urandom_range(4, 255)), 16'($urandom));

      rx_style = rx_style_e'($urandom_range(0, 2));
      tx_gappy = $urandom_range(0, 1);
      if (p == 0 || p == 7) begin
        tx_gappy = 1'b0;
        hold_request = 1'b1;
      end

      // mostly command-then-ticks sequences, some spare kinds as noise
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) kind_v = KindOpen;
        else if (pick < 8) kind_v = KindClose;
        else if (pick < 10) kind_v = KindSpare;
        else kind_v = KindTick;
        offer_item(kind_v, 1'($urandom), 1'($urandom));
        pending_positions.push_back(advance_shutter(kind_v, s_axis_tdata[0], s_axis_tdata[1]));
      end
    end

    await_drain();
    if (pending_positions.size() != 0)
      flag_mismatch("results never delivered", pending_positions.size(), 0);

    $display("Run covered %0d input items (%0d open/close commands), %0d results checked",
             items_sent, commands_sent, results_seen);
    $display("%0d confirmed positions, %0d register writes, %0d long output stalls",
             confirms_seen, writes_done, long_holds);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
